// File: src/stpid_pkg.sv
// Shared types, widths and codes for the slip traction PID block.
package stpid_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int FIELD_W     = 16;
    localparam int SPD_W       = (SPEED_WIDTH < FIELD_W) ? SPEED_WIDTH : FIELD_W;
    localparam int SUM_W       = SPD_W + 1;
    localparam int QUO_W       = SUM_W + 16;
    localparam int DIV_STEPS   = QUO_W;
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);

    localparam int GAIN_W  = 16;
    localparam int THR_W   = 23;
    localparam int SLIP_W  = 24;
    localparam int PREV_W  = 25;
    localparam int INTEG_W = 32;
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int MULT_W  = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [SLIP_W-1:0] SLIP_MAX = 24'd8388607;
    localparam logic [MULT_W-1:0] ONE_Q16  = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_NORMAL = 3'd0,
        REG_KI_NORMAL = 3'd1,
        REG_KD_NORMAL = 3'd2,
        REG_KP_HIGH   = 3'd3,
        REG_KI_HIGH   = 3'd4,
        REG_KD_HIGH   = 3'd5,
        REG_SLIP_THR  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_normal;
        logic [GAIN_W-1:0] ki_normal;
        logic [GAIN_W-1:0] kd_normal;
        logic [GAIN_W-1:0] kp_high;
        logic [GAIN_W-1:0] ki_high;
        logic [GAIN_W-1:0] kd_high;
        logic [THR_W-1:0]  slip_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SLIP,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     slip_upd;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_clr;
        logic     acc_add;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// File: src/stpid_cfg.sv
// Configuration register file: gains and slip threshold.
module stpid_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [stpid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stpid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output stpid_pkg::t_cfg                  o_cfg
);
    import stpid_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_normal  <= 16'd13107;
            r_cfg.ki_normal  <= 16'd1311;
            r_cfg.kd_normal  <= 16'd6554;
            r_cfg.kp_high    <= 16'd19661;
            r_cfg.ki_high    <= 16'd1966;
            r_cfg.kd_high    <= 16'd9830;
            r_cfg.slip_limit <= 23'd6554;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KP_NORMAL: r_cfg.kp_normal  <= i_cfg_data[GAIN_W-1:0];
                REG_KI_NORMAL: r_cfg.ki_normal  <= i_cfg_data[GAIN_W-1:0];
                REG_KD_NORMAL: r_cfg.kd_normal  <= i_cfg_data[GAIN_W-1:0];
                REG_KP_HIGH:   r_cfg.kp_high    <= i_cfg_data[GAIN_W-1:0];
                REG_KI_HIGH:   r_cfg.ki_high    <= i_cfg_data[GAIN_W-1:0];
                REG_KD_HIGH:   r_cfg.kd_high    <= i_cfg_data[GAIN_W-1:0];
                REG_SLIP_THR:  r_cfg.slip_limit <= i_cfg_data[THR_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/stpid_ctrl.sv
// Controller state machine sequencing divide, PID multiplies and output.
module stpid_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stpid_pkg::t_status  i_status,
    output stpid_pkg::t_cmd     o_cmd
);
    import stpid_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             div_last;

    assign div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (div_last) n_state = S_SLIP;
            end
            S_SLIP:  n_state = S_MUL_P;
            S_MUL_P: n_state = S_MUL_I;
            S_MUL_I: n_state = S_MUL_D;
            S_MUL_D: n_state = S_ACC;
            S_ACC:   n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_P;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_SLIP:  o_cmd.slip_upd = 1'b1;
            S_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
                o_cmd.acc_clr = 1'b1;
            end
            S_MUL_I: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_I;
                o_cmd.acc_add = 1'b1;
            end
            S_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D;
                o_cmd.acc_add = 1'b1;
            end
            S_ACC:   o_cmd.acc_add  = 1'b1;
            S_DONE:  o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_DIV && r_cnt == '0))
        else $error("accepted item did not start the divider");

    a_div_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider step count overran");

    a_done_waits_for_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_status.out_free) |=> (r_state == S_DONE))
        else $error("result dropped while output register full");

endmodule

// File: src/stpid_dp.sv
// Datapath: wheel sums, restoring divider, PID state, shared multiplier, output register.
module stpid_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stpid_pkg::t_cmd               i_cmd,
    output stpid_pkg::t_status            o_status,
    input  stpid_pkg::t_cfg               i_cfg,
    input  logic [stpid_pkg::FIELD_W-1:0] i_fl,
    input  logic [stpid_pkg::FIELD_W-1:0] i_fr,
    input  logic [stpid_pkg::FIELD_W-1:0] i_rl,
    input  logic [stpid_pkg::FIELD_W-1:0] i_rr,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [stpid_pkg::MULT_W-1:0]  o_mult,
    output logic signed [stpid_pkg::SLIP_W-1:0] o_slip,
    output logic                          o_high,
    output logic                          o_reducing
);
    import stpid_pkg::*;

    // operand capture and divider
    logic [SUM_W-1:0] front, rear, diff;
    logic             neg;
    logic [SUM_W-1:0] r_front;
    logic             r_neg, r_fzero;
    logic [SUM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [SUM_W:0]   trial;
    logic             q_bit;

    assign front = SUM_W'(i_fl[SPD_W-1:0]) + SUM_W'(i_fr[SPD_W-1:0]);
    assign rear  = SUM_W'(i_rl[SPD_W-1:0]) + SUM_W'(i_rr[SPD_W-1:0]);
    assign neg   = (rear < front);
    assign diff  = neg ? (front - rear) : (rear - front);
    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign q_bit = (trial >= {1'b0, r_front});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_front <= front;
            r_neg   <= neg;
            r_fzero <= (front == '0);
            r_rem   <= '0;
            r_quo   <= {diff, 16'd0};
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? SUM_W'(trial - {1'b0, r_front}) : SUM_W'(trial);
            r_quo <= {r_quo[QUO_W-2:0], q_bit};
        end
    end

    // slip saturation, gain selection, integral and derivative
    logic signed [SLIP_W-1:0]  slip_new;
    logic                      high_new;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [SLIP_W-1:0]  r_slip;
    logic signed [PREV_W-1:0]  r_prev;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [PREV_W:0]    r_deriv;
    logic                      r_high;
    logic [GAIN_W-1:0]         r_kp, r_ki, r_kd;

    always_comb begin
        if (r_fzero) begin
            slip_new = '0;
        end else if (!r_neg) begin
            slip_new = (r_quo > QUO_W'(SLIP_MAX)) ? SLIP_MAX : SLIP_W'(r_quo);
        end else if (r_quo > QUO_W'(ONE_Q16)) begin
            slip_new = -SLIP_W'(ONE_Q16);
        end else begin
            slip_new = -SLIP_W'(r_quo);
        end
    end

    // signed compare: negative slip never selects the high set
    assign high_new  = (slip_new > $signed({1'b0, i_cfg.slip_limit}));
    assign integ_sum = (INTEG_W + 1)'(r_integ) + (INTEG_W + 1)'(slip_new);

    always_comb begin
        if (integ_sum > $signed({2'b00, {(INTEG_W - 1){1'b1}}})) begin
            integ_new = {1'b0, {(INTEG_W - 1){1'b1}}};
        end else if (integ_sum < $signed({2'b11, {(INTEG_W - 1){1'b0}}})) begin
            integ_new = {1'b1, {(INTEG_W - 1){1'b0}}};
        end else begin
            integ_new = integ_sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_cmd.slip_upd) begin
            r_integ <= integ_new;
            r_prev  <= PREV_W'(slip_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slip_upd) begin
            r_slip  <= slip_new;
            r_deriv <= (PREV_W + 1)'(slip_new) - (PREV_W + 1)'(r_prev);
            r_high  <= high_new;
            r_kp    <= high_new ? i_cfg.kp_high : i_cfg.kp_normal;
            r_ki    <= high_new ? i_cfg.ki_high : i_cfg.ki_normal;
            r_kd    <= high_new ? i_cfg.kd_high : i_cfg.kd_normal;
        end
    end

    // shared multiplier and accumulator
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_P: begin
                mul_a = $signed({1'b0, r_kp});
                mul_b = MUL_B_W'(r_slip);
            end
            MUL_I: begin
                mul_a = $signed({1'b0, r_ki});
                mul_b = MUL_B_W'(r_integ);
            end
            MUL_D: begin
                mul_a = $signed({1'b0, r_kd});
                mul_b = MUL_B_W'(r_deriv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // cut = clamp(pid, 0, 1.0) in Q.16
    logic [MULT_W-1:0] cut;

    always_comb begin
        if (r_acc[ACC_W-1] || r_acc == '0) begin
            cut = '0;
        end else if (r_acc[ACC_W-2:32] != '0) begin
            cut = ONE_Q16;
        end else begin
            cut = MULT_W'(r_acc[31:16]);
        end
    end

    // output register
    logic r_valid;

    assign o_status.out_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_mult     <= ONE_Q16 - cut;
            o_slip     <= r_slip;
            o_high     <= r_high;
            o_reducing <= (cut != '0);
        end
    end

    assign o_valid = r_valid;

endmodule

// File: src/slip_traction_pid.sv
// Top level of the gain-scheduled slip traction PID controller.
// Each input transfer passes through 33 divider steps of the restoring divider,
//   a slip update, 4 multiply/accumulate steps and an output load before the result is valid.
// Only one item is in flight: the next transfer is taken in the idle state once the
//   result has been loaded; the serial divider dominates, and the block also waits
//   while the output register stays full.
// Reset (i_rst_n low, synchronous): gains and threshold to defaults, integral and
//   previous slip to zero, no result pending.
module slip_traction_pid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] front_left_speed, [31:16] front_right_speed,
    // [47:32] rear_left_speed, [63:48] rear_right_speed
    input  logic [63:0] s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] torque_multiplier, [40:17] slip_ratio, [47:41] zero
    output logic [47:0] m_axis_tdata,
    // [0] high_gain_active, [1] reducing
    output logic [1:0]  m_axis_tuser,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [stpid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stpid_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import stpid_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    logic [MULT_W-1:0]        mult;
    logic signed [SLIP_W-1:0] slip;
    logic                     high, reducing;

    // registers always take a write transfer
    assign o_cfg_ready = 1'b1;

    stpid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer: one item in flight, ready only when idle
    stpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic and the output register, which parts the two stream sides
    stpid_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_cfg      (cfg),
        .i_fl       (s_axis_tdata[15:0]),
        .i_fr       (s_axis_tdata[31:16]),
        .i_rl       (s_axis_tdata[47:32]),
        .i_rr       (s_axis_tdata[63:48]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_mult     (mult),
        .o_slip     (slip),
        .o_high     (high),
        .o_reducing (reducing)
    );

    assign m_axis_tdata = {7'd0, slip, mult};
    assign m_axis_tuser = {reducing, high};

endmodule
